// ===== sv/swm_pkg.sv =====
// Shared types and constants for the sliding-window median filter.
package swm_pkg;

  localparam int SAMPLE_W = 32;
  localparam int REG_W    = 5;

  // Configuration register indexes.
  localparam logic [0:0] CFG_WINDOW_LENGTH = 1'b0;
  localparam logic [0:0] CFG_MIN_COUNT     = 1'b1;

  // Operation broadcast to every cell of the sorted chain.
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_DROP,
    CMD_INSERT
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t                   cmd;
    logic signed [SAMPLE_W-1:0] sample;
  } cell_ctrl_t;

endpackage

// ===== sv/swm_cell.sv =====
// One cell of the sorted sample chain: holds a sample and its age.
module swm_cell #(
  parameter int AW = 4
) (
  input  logic                                 clk,
  input  swm_pkg::cell_ctrl_t                  ctrl,
  input  logic                                 valid,
  input  logic                                 shift_down,
  input  logic [AW-1:0]                        drop_age,
  input  logic signed [swm_pkg::SAMPLE_W-1:0]  lo_val,
  input  logic [AW-1:0]                        lo_age,
  input  logic                                 lo_gt,
  input  logic signed [swm_pkg::SAMPLE_W-1:0]  hi_val,
  input  logic [AW-1:0]                        hi_age,
  output logic signed [swm_pkg::SAMPLE_W-1:0]  val,
  output logic [AW-1:0]                        age,
  output logic                                 gt,
  output logic                                 hit
);

  // The new sample belongs at or below this cell; empty cells count as larger.
  assign gt  = !valid || (ctrl.sample < val);
  assign hit = valid && (age == drop_age);

  always_ff @(posedge clk) begin
    unique case (ctrl.cmd)
      swm_pkg::CMD_DROP: begin
        if (shift_down) begin
          val <= hi_val;
          age <= hi_age;
        end
      end
      swm_pkg::CMD_INSERT: begin
        if (lo_gt) begin
          val <= lo_val;
          age <= lo_age + AW'(1);
        end else if (gt) begin
          val <= ctrl.sample;
          age <= '0;
        end else begin
          age <= age + AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/sliding_window_median.sv =====
// Top level of the sliding-window lower-median filter built on a sorted cell chain.
// A push runs through the update step, which drops the oldest samples while the window is too
// full (as after window_length was lowered without a clear) and then inserts the new sample,
// and then the report step; a clear goes straight to the report step. The next request enters
// once the report is written, and the report waits while the previous result is still stalled.
// Reset (rst, synchronous): window empty, window_length 16, min_count 1, no result pending.
module sliding_window_median #(
  parameter int MAX_WINDOW = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write port.
  input  logic                                 cfg_write,
  input  logic [0:0]                           cfg_index,
  input  logic [swm_pkg::REG_W-1:0]            cfg_data,
  // Request channel.
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 kind,
  input  logic signed [swm_pkg::SAMPLE_W-1:0]  sample,
  // Result channel.
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [swm_pkg::SAMPLE_W-1:0]  smoothed_value,
  output logic [$clog2(MAX_WINDOW+1)-1:0]      sample_count,
  output logic                                 is_empty
);

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LW    = (CNT_W > swm_pkg::REG_W) ? CNT_W : swm_pkg::REG_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_REPORT
  } state_t;

  state_t                               state;
  logic [swm_pkg::REG_W-1:0]            window_length;
  logic [swm_pkg::REG_W-1:0]            min_count;
  logic [CNT_W-1:0]                     fill;
  logic                                 kind_q;
  logic signed [swm_pkg::SAMPLE_W-1:0]  sample_q;

  // The window length saturates at the chain depth.
  logic [LW-1:0] len;
  logic [LW-1:0] fill_ext;
  logic          need_drop;
  logic          use_median;
  logic [CNT_W-1:0] fill_m1;
  logic [AW-1:0]    mid_idx;
  logic             report_go;

  assign len = (LW'(window_length) > LW'(MAX_WINDOW)) ? LW'(MAX_WINDOW) : LW'(window_length);
  assign fill_ext   = LW'(fill);
  assign need_drop  = (fill != '0) && (fill_ext >= len);
  assign use_median = fill_ext >= LW'(min_count);
  assign fill_m1    = fill - CNT_W'(1);
  assign mid_idx    = AW'(fill_m1 >> 1);

  assign in_stall = (state != S_IDLE);

  // The report step writes the output register when it is empty or being emptied.
  assign report_go = (state == S_REPORT) && (!out_valid || !out_stall);

  // Chain control. While the window is too full for the new sample, the oldest is removed
  // one per cycle; then, for a nonzero length, the new sample is inserted in sorted position.
  swm_pkg::cell_ctrl_t ctrl;

  always_comb begin
    ctrl.sample = sample_q;
    ctrl.cmd    = swm_pkg::CMD_HOLD;
    if (state == S_UPDATE) begin
      if (need_drop) begin
        ctrl.cmd = swm_pkg::CMD_DROP;
      end else if (len != '0) begin
        ctrl.cmd = swm_pkg::CMD_INSERT;
      end
    end
  end

  // Cell array. Cells below the fill count hold samples sorted ascending from cell 0.
  logic signed [swm_pkg::SAMPLE_W-1:0] cell_val [MAX_WINDOW];
  logic [AW-1:0]                       cell_age [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]               cell_gt;
  logic [MAX_WINDOW-1:0]               cell_hit;
  logic [MAX_WINDOW-1:0]               cell_valid;
  logic [MAX_WINDOW-1:0]               cell_shift;
  logic [MAX_WINDOW-1:0]               order_err;
  logic [AW-1:0]                       drop_age;

  // The oldest sample always carries age fill-1, since only the newest ones are kept.
  assign drop_age = AW'(fill_m1);

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic signed [swm_pkg::SAMPLE_W-1:0] lo_val;
    logic [AW-1:0]                       lo_age;
    logic                                lo_gt;
    logic signed [swm_pkg::SAMPLE_W-1:0] hi_val;
    logic [AW-1:0]                       hi_age;

    assign cell_valid[i] = CNT_W'(i) < fill;
    // A cell moves down when the dropped sample sits at or below it.
    assign cell_shift[i] = |cell_hit[i:0];

    if (i == 0) begin : g_bottom
      assign lo_val = '0;
      assign lo_age = '0;
      assign lo_gt  = 1'b0;
    end else begin : g_lower
      assign lo_val = cell_val[i-1];
      assign lo_age = cell_age[i-1];
      assign lo_gt  = cell_gt[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_top
      assign hi_val       = '0;
      assign hi_age       = '0;
      assign order_err[i] = 1'b0;
    end else begin : g_upper
      assign hi_val       = cell_val[i+1];
      assign hi_age       = cell_age[i+1];
      assign order_err[i] = cell_valid[i+1] && (cell_val[i] > cell_val[i+1]);
    end

    swm_cell #(
      .AW (AW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .valid      (cell_valid[i]),
      .shift_down (cell_shift[i]),
      .drop_age   (drop_age),
      .lo_val     (lo_val),
      .lo_age     (lo_age),
      .lo_gt      (lo_gt),
      .hi_val     (hi_val),
      .hi_age     (hi_age),
      .val        (cell_val[i]),
      .age        (cell_age[i]),
      .gt         (cell_gt[i]),
      .hit        (cell_hit[i])
    );
  end

  // Sequencer, configuration registers and output register. A request is taken in idle,
  // the chain is updated, and the report step writes the result once the output register
  // is free. Below min_count the newest sample, which is the one just pushed, is reported.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      fill          <= '0;
      out_valid     <= 1'b0;
      window_length <= swm_pkg::REG_W'(16);
      min_count     <= swm_pkg::REG_W'(1);
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          swm_pkg::CFG_WINDOW_LENGTH: window_length <= cfg_data;
          swm_pkg::CFG_MIN_COUNT:     min_count     <= cfg_data;
        endcase
      end

      if (report_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind_q   <= kind;
            sample_q <= sample;
            if (kind) begin
              fill  <= '0;
              state <= S_REPORT;
            end else begin
              state <= S_UPDATE;
            end
          end
        end
        S_UPDATE: begin
          if (need_drop) begin
            fill <= fill_m1;
          end else begin
            if (len != '0) begin
              fill <= fill + CNT_W'(1);
            end
            state <= S_REPORT;
          end
        end
        S_REPORT: begin
          if (report_go) begin
            sample_count <= fill;
            is_empty     <= (fill == '0);
            if (fill == '0) begin
              smoothed_value <= '0;
            end else if (use_median) begin
              smoothed_value <= cell_val[mid_idx];
            end else begin
              smoothed_value <= sample_q;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(MAX_WINDOW))
    else $error("fill count exceeds chain depth");

  a_fill_fits: assert property (@(posedge clk) disable iff (rst)
    (state == S_REPORT) && !kind_q |-> fill_ext <= len)
    else $error("window holds more samples than window_length");

  a_sorted: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (order_err == '0))
    else $error("cell chain not sorted");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (sample_count == '0)))
    else $error("empty flag disagrees with sample count");
`endif

endmodule

// ===== sim/sliding_window_median_test.sv =====
// Self-checking testbench for the sliding-window lower-median filter.
module sliding_window_median_test;
  timeunit 1ns;
  timeprecision 1ps;

  // The window store depth used both by the block instance and by the predictor below.
  localparam int MAX_WIN = 16;
  localparam int CNT_W = $clog2(MAX_WIN + 1);

  // Request kinds on the input channel.
  localparam logic KIND_PUSH  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // Extremes of the signed Q16.16 sample range.
  localparam logic signed [swm_pkg::SAMPLE_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [swm_pkg::SAMPLE_W-1:0] Q_MIN = 32'sh8000_0000;

  // Length of the long receiver hold-off, in cycles. It is long enough for the block to
  // finish its current request, park the result and then stall the sender.
  localparam int LONG_HOLD = 120;

  // Number of random phases and requests per phase; together about 700 requests.
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_REQUESTS = 58;

  typedef struct {
    logic                                op;
    logic signed [swm_pkg::SAMPLE_W-1:0] value;
  } window_request_t;

  typedef struct {
    logic signed [swm_pkg::SAMPLE_W-1:0] value;
    logic [CNT_W-1:0]                    count;
    logic                                empty;
  } smooth_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                cfg_write = 1'b0;
  logic [0:0]                          cfg_index = swm_pkg::CFG_WINDOW_LENGTH;
  logic [swm_pkg::REG_W-1:0]           cfg_data = '0;

  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic                                kind = KIND_PUSH;
  logic signed [swm_pkg::SAMPLE_W-1:0] sample = '0;

  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic signed [swm_pkg::SAMPLE_W-1:0] smoothed_value;
  logic [CNT_W-1:0]                    sample_count;
  logic                                is_empty;

  sliding_window_median #(
    .MAX_WINDOW(MAX_WIN)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .sample(sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .smoothed_value(smoothed_value),
    .sample_count(sample_count),
    .is_empty(is_empty)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Requests waiting to be offered, and the results the predictor has worked out for
  // requests that the block has already accepted, oldest first.
  window_request_t request_queue[$];
  smooth_result_t  awaited_results[$];

  // The predictor's own copy of the configuration and of the window.
  logic [swm_pkg::REG_W-1:0]           win_len;
  logic [swm_pkg::REG_W-1:0]           win_min;
  logic signed [swm_pkg::SAMPLE_W-1:0] win_store[MAX_WIN];
  int                                  win_fill;
  int                                  win_head;

  // Pacing controls set by the stimulus process, and per-channel countdowns.
  logic tx_burst = 1'b0;
  logic rx_burst = 1'b0;
  logic hold_go = 1'b0;
  int   hold_left = 0;
  int   tx_gap = 0;
  int   rx_wait = 0;

  int mismatch_count = 0;
  int results_checked = 0;
  int pushes_sent = 0;
  int clears_sent = 0;
  int settings_used = 0;

  // Applies one request to the predictor's window and returns the result that the block
  // must report for it. A clear empties the window. A push first drops the oldest samples
  // until the new one fits, which also covers a window that was shortened without a
  // clear; a window length of zero stores nothing, and lengths above the store depth act
  // as the full depth. Once the fill reaches min_count the lower median is reported,
  // otherwise the newest sample; an empty window reports zero with the empty flag.
  function automatic smooth_result_t smooth_next(
    logic                                op,
    logic signed [swm_pkg::SAMPLE_W-1:0] value
  );
    smooth_result_t                      res;
    int                                  len;
    int                                  rank;
    int                                  below;
    int                                  not_above;
    logic signed [swm_pkg::SAMPLE_W-1:0] cand;
    logic signed [swm_pkg::SAMPLE_W-1:0] other;
    len = (win_len > MAX_WIN) ? MAX_WIN : int'(win_len);
    if (op == KIND_CLEAR) begin
      win_fill = 0;
      win_head = 0;
    end else begin
      while (win_fill > 0 && win_fill >= len) begin
        win_head = (win_head + 1) % MAX_WIN;
        win_fill--;
      end
      if (len > 0) begin
        win_store[(win_head + win_fill) % MAX_WIN] = value;
        win_fill++;
      end
      if (win_fill == 0) win_head = 0;
    end
    res.value = '0;
    res.count = CNT_W'(win_fill);
    res.empty = (win_fill == 0);
    if (win_fill > 0) begin
      if (win_fill >= int'(win_min)) begin
        // The lower median is the sample whose rank range covers index (n-1)/2.
        rank = (win_fill - 1) / 2;
        for (int i = 0; i < win_fill; i++) begin
          cand = win_store[(win_head + i) % MAX_WIN];
          below = 0;
          not_above = 0;
          for (int j = 0; j < win_fill; j++) begin
            other = win_store[(win_head + j) % MAX_WIN];
            if (other < cand) below++;
            if (other <= cand) not_above++;
          end
          if (below <= rank && rank < not_above) res.value = cand;
        end
      end else begin
        res.value = win_store[(win_head + win_fill - 1) % MAX_WIN];
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what);
    if (mismatch_count < 50) $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Request driver. At each rising edge it first books an accepted request with the
  // predictor, using the payload that was on the port before the edge. It then decides
  // what to offer next: a request that is held off by stall keeps its payload, and a new
  // one is offered only after the drawn gap has run out. Valid is never derived from stall.
  always @(posedge clk) begin
    window_request_t req;
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        awaited_results = {awaited_results, smooth_next(kind, sample)};
        tx_gap = tx_burst ? 0 : $urandom_range(0, 14);
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap == 0 && request_queue.size() != 0) begin
          req = request_queue.pop_front();
          in_valid <= 1'b1;
          kind <= req.op;
          sample <= req.value;
        end else begin
          in_valid <= 1'b0;
          if (tx_gap != 0) tx_gap--;
        end
      end
    end
  end

  // The long hold-off runs in a process of its own, so the receiver's normal per-result
  // stalls keep going underneath it.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= LONG_HOLD;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor. Every accepted result is compared field by field with the oldest
  // prediction; a result with nothing awaited is a failure of its own. After each result
  // the receiver draws how many cycles it stalls before taking the next one.
  always @(posedge clk) begin
    smooth_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_checked++;
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result value %0d count %0d with no request outstanding",
                                    smoothed_value, sample_count));
        end else begin
          want = awaited_results.pop_front();
          if (smoothed_value !== want.value)
            report_mismatch($sformatf("smoothed_value %0d, predicted %0d",
                                      smoothed_value, want.value));
          if (sample_count !== want.count)
            report_mismatch($sformatf("sample_count %0d, predicted %0d",
                                      sample_count, want.count));
          if (is_empty !== want.empty)
            report_mismatch($sformatf("is_empty %0b, predicted %0b", is_empty, want.empty));
        end
        rx_wait = rx_burst ? 0 : $urandom_range(0, 14);
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      out_stall <= (rx_wait != 0) || (hold_left != 0);
    end
  end

  task automatic queue_req(logic op, logic signed [swm_pkg::SAMPLE_W-1:0] value);
    window_request_t req;
    req.op = op;
    req.value = value;
    request_queue = {request_queue, req};
    if (op == KIND_CLEAR) clears_sent++;
    else pushes_sent++;
  endtask

  // Waits until nothing is queued, nothing is offered and no result is outstanding, then
  // lets a few more cycles pass. The idle test is made at the falling edge, where every
  // update of the rising edge has settled.
  task automatic wait_idle(int settle);
    @(negedge clk);
    while (request_queue.size() != 0 || in_valid || awaited_results.size() != 0)
      @(negedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Writes both registers; the block is idle whenever this is called.
  task automatic set_regs(
    logic [swm_pkg::REG_W-1:0] len,
    logic [swm_pkg::REG_W-1:0] min_fill
  );
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= swm_pkg::CFG_WINDOW_LENGTH;
    cfg_data <= len;
    @(posedge clk);
    cfg_index <= swm_pkg::CFG_MIN_COUNT;
    cfg_data <= min_fill;
    @(posedge clk);
    cfg_write <= 1'b0;
    win_len = len;
    win_min = min_fill;
    settings_used++;
  endtask

  // Samples mix the full random range, a narrow band that produces many equal values,
  // whole Q16.16 numbers and the two extremes.
  function automatic logic signed [swm_pkg::SAMPLE_W-1:0] draw_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $signed($urandom_range(0, 16)) - 8;
      7:          return Q_MAX;
      8:          return Q_MIN;
      default:    return ($signed($urandom_range(0, 400)) - 200) <<< 16;
    endcase
  endfunction

  initial begin
    #(2_000_000);
    $display("sliding_window_median_test: errors");
    $finish;
  end

  initial begin
    logic [swm_pkg::REG_W-1:0] len;
    logic [swm_pkg::REG_W-1:0] min_fill;
    win_len = swm_pkg::REG_W'(16);
    win_min = swm_pkg::REG_W'(1);
    win_fill = 0;
    win_head = 0;
    for (int i = 0; i < MAX_WIN; i++) win_store[i] = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: a clear of an empty window, then the sample extremes, zero and
    // minus one; with min_count 1 each of these reports the median at once.
    queue_req(KIND_CLEAR, Q_MAX);
    queue_req(KIND_PUSH, Q_MAX);
    queue_req(KIND_PUSH, Q_MIN);
    queue_req(KIND_PUSH, '0);
    queue_req(KIND_PUSH, -1);
    wait_idle(8);

    // A short window that overflows, with the newest sample reported below min_count.
    set_regs(swm_pkg::REG_W'(3), swm_pkg::REG_W'(2));
    queue_req(KIND_CLEAR, '0);
    queue_req(KIND_PUSH, 5);
    queue_req(KIND_PUSH, 3);
    queue_req(KIND_PUSH, 9);
    queue_req(KIND_PUSH, 1);
    wait_idle(8);

    // Window shortened without a clear: the next push drops old samples until it fits.
    set_regs(swm_pkg::REG_W'(1), swm_pkg::REG_W'(2));
    queue_req(KIND_PUSH, 7);
    wait_idle(8);

    // A window length of zero keeps nothing at all.
    set_regs(swm_pkg::REG_W'(0), swm_pkg::REG_W'(2));
    queue_req(KIND_PUSH, 4);
    queue_req(KIND_CLEAR, '0);
    wait_idle(8);

    // A length above the store depth saturates; min_count zero always takes the median.
    set_regs(swm_pkg::REG_W'(31), swm_pkg::REG_W'(0));
    queue_req(KIND_PUSH, 10);
    queue_req(KIND_PUSH, 20);
    queue_req(KIND_PUSH, -20);
    wait_idle(8);

    // A min_count above any reachable fill always reports the newest sample.
    set_regs(swm_pkg::REG_W'(31), swm_pkg::REG_W'(31));
    queue_req(KIND_PUSH, 30);
    wait_idle(8);

    // Random phases. The first four pin settings, most at register extremes, the rest draw
    // settings, mostly short windows. Most phases start with a clear, as software would; the
    // others leave the window in place, which covers shrinking and growing without a clear.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin len = swm_pkg::REG_W'(16); min_fill = swm_pkg::REG_W'(1); end
        1: begin len = swm_pkg::REG_W'(1); min_fill = swm_pkg::REG_W'(16); end
        2: begin len = swm_pkg::REG_W'(5); min_fill = swm_pkg::REG_W'(3); end
        3: begin len = swm_pkg::REG_W'(31); min_fill = swm_pkg::REG_W'(0); end
        default: begin
          case ($urandom_range(0, 9))
            0:       len = swm_pkg::REG_W'(0);
            1:       len = swm_pkg::REG_W'($urandom_range(17, 31));
            2:       len = swm_pkg::REG_W'(16);
            default: len = swm_pkg::REG_W'($urandom_range(1, 8));
          endcase
          case ($urandom_range(0, 5))
            0:       min_fill = swm_pkg::REG_W'(0);
            1:       min_fill = swm_pkg::REG_W'($urandom_range(0, 31));
            default: min_fill = swm_pkg::REG_W'($urandom_range(1, 9));
          endcase
        end
      endcase
      wait_idle(8);
      set_regs(len, min_fill);
      // Phase 2 is the pressure phase: the sender offers back to back while the receiver
      // holds off for a long stretch, so the block fills up and stalls its input.
      tx_burst <= (p == 2) || ($urandom_range(0, 3) == 0);
      rx_burst <= (p != 2) && ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) queue_req(KIND_CLEAR, draw_sample());
      for (int i = 0; i < PHASE_REQUESTS; i++) begin
        if ($urandom_range(0, 9) == 0) queue_req(KIND_CLEAR, draw_sample());
        else queue_req(KIND_PUSH, draw_sample());
      end
      if (p == 2) begin
        @(posedge clk);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
    end

    // Drain: every result must have come back, then a quiet stretch in which any stray
    // result would still be caught by the monitor.
    wait_idle(20);
    $display("Checked %0d results for %0d pushes and %0d clears under %0d register settings.",
             results_checked, pushes_sent, clears_sent, settings_used);
    $display("Mismatches found: %0d.", mismatch_count);
    if (mismatch_count == 0) begin
      $display("sliding_window_median_test: clean");
    end else begin
      $display("sliding_window_median_test: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/swm_pkg.sv
sv/swm_cell.sv
sv/sliding_window_median.sv
sim/sliding_window_median_test.sv
